[rtl/core/imgc_pkg.sv]
package imgc_pkg;

   // sizes
   localparam int MaxSize   = 1024;
   localparam int MaxRadius = 2;
   localparam int CoefBits  = 16;
   localparam int WinSide   = 2 * MaxRadius + 1;
   localparam int PixBits   = 8;
   localparam int SizeBits  = 11;
   localparam int RadBits   = 2;
   localparam int PosBits   = 21;
   localparam int ColBits   = $clog2(MaxSize);
   localparam int LineBits  = (WinSide - 1) * PixBits;
   localparam int ProdBits  = PixBits + CoefBits + 1;
   localparam int PartBits  = ProdBits + $clog2(WinSide);
   localparam int SumBits   = PartBits + $clog2(WinSide);
   localparam int FifoDepth = 8;
   localparam int FifoBits  = $clog2(FifoDepth);
   localparam int PixMax    = 255;

   // commands
   localparam logic [1:0] CmdLoad  = 2'd0;
   localparam logic [1:0] CmdPixel = 2'd1;
   localparam logic [1:0] CmdDrain = 2'd2;

   // register indexes
   localparam logic [0:0] RegSize   = 1'b0;
   localparam logic [0:0] RegRadius = 1'b1;

   typedef logic [PixBits-1:0] pix_type;
   typedef logic signed [CoefBits-1:0] coef_type;
   typedef pix_type [WinSide-1:0] col_type;
   typedef coef_type [WinSide-1:0] coef_col_type;
   typedef logic signed [PartBits-1:0] part_type;

   // control that travels alongside the datapath stages
   typedef struct packed {
      logic shift;
      logic result;
      logic border;
      logic last;
   } ctrl_type;

endpackage

[rtl/core/imgc_line_buf.sv]
module imgc_line_buf (
   input  logic                                    clock,
   input  logic                                    rd_en,
   input  logic [imgc_pkg::ColBits-1:0]            rd_addr,
   output logic [imgc_pkg::LineBits-1:0]           rd_data,
   input  logic                                    wr_en,
   input  logic [imgc_pkg::ColBits-1:0]            wr_addr,
   input  logic [imgc_pkg::LineBits-1:0]           wr_data
);

   logic [imgc_pkg::LineBits-1:0] mem_ff [imgc_pkg::MaxSize];
   logic [imgc_pkg::LineBits-1:0] rd_data_ff;

   // one column of the previous rows per address
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/imgc_cell.sv]
module imgc_cell (
   input  logic                       clock,
   input  logic                       shift,
   input  imgc_pkg::col_type          col_in,
   input  imgc_pkg::coef_col_type     coef_col,
   output imgc_pkg::col_type          col_out,
   output imgc_pkg::part_type         part_out
);

   imgc_pkg::col_type  col_ff;
   imgc_pkg::part_type part_ff;
   imgc_pkg::part_type part_in;
   logic signed [imgc_pkg::ProdBits-1:0] prod [imgc_pkg::WinSide];

   // window column, handed on to the left neighbor on every pixel
   always_ff @(posedge clock) begin
      if (shift) begin
         col_ff <= col_in;
      end
      part_ff <= part_in;
   end

   // column dot product, zero weights keep unread rows out of the sum
   always_comb begin
      part_in = '0;
      for (int e = 0; e < imgc_pkg::WinSide; e++) begin
         if (coef_col[e] == '0) begin
            prod[e] = '0;
         end else begin
            prod[e] = imgc_pkg::ProdBits'($signed({1'b0, col_ff[e]}))
                      * imgc_pkg::ProdBits'(coef_col[e]);
         end
         part_in = part_in + imgc_pkg::PartBits'(prod[e]);
      end
   end

   assign col_out  = col_ff;
   assign part_out = part_ff;

endmodule

[rtl/core/image_convolution_clamped.sv]
// 2-D correlation filter over a square 8-bit image streamed in raster order,
// window side 2r+1 (r up to 2), result clamped to 0..255, borders give 0.
// req channel: command selects a coefficient load (coef_row, coef_col,
// coef_value), a pixel (pixel) or a drain beat that flushes one pending
// result once the whole image is in. rsp channel: out_pixel, with out_last
// on the final result of the image. csr channel: index 0 image size,
// index 1 kernel radius; a write restarts the image and req_ready drops for
// one cycle afterwards. csr_ready is always high.
// Throughput is one beat per clock while req_ready is high. A beat that
// releases a result sends it through line buffer read, window shift in the
// column cells, column products, window sum, then a clamp into an
// 8-entry output queue. A result trails its pixel by r*N+r pixels.
// When the receiver stalls the queue fills and req_ready falls once queued
// plus in-flight results reach 8; nothing is lost.
// Reset clears the counters, coefficients and queue and restores N=8, r=1.
module image_convolution_clamped (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [1:0]                            req_command,
   input  logic [2:0]                            req_coef_row,
   input  logic [2:0]                            req_coef_col,
   input  logic signed [imgc_pkg::CoefBits-1:0]  req_coef_value,
   input  logic [imgc_pkg::PixBits-1:0]          req_pixel,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [imgc_pkg::PixBits-1:0]          rsp_out_pixel,
   output logic                                  rsp_out_last,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [0:0]                            csr_index,
   input  logic [imgc_pkg::SizeBits-1:0]         csr_data
);

   localparam int W = imgc_pkg::WinSide;

   // configuration
   logic [imgc_pkg::SizeBits-1:0] size_ff;
   logic [imgc_pkg::RadBits-1:0]  radius_ff;
   logic                          settle_ff;
   logic [imgc_pkg::SizeBits-1:0] n_eff;
   logic [imgc_pkg::RadBits-1:0]  r_eff;
   logic [imgc_pkg::PosBits-1:0]  nn_ff;
   logic [imgc_pkg::PosBits-1:0]  delay_ff;
   logic [imgc_pkg::PosBits-1:0]  delay_in;

   // position counters
   logic [imgc_pkg::SizeBits-1:0] in_row_ff, in_row_in, in_col_ff, in_col_in;
   logic [imgc_pkg::SizeBits-1:0] out_row_ff, out_row_in, out_col_ff, out_col_in;
   logic [imgc_pkg::PosBits-1:0]  q_ff, q_in, out_pos_ff, out_pos_in;

   // coefficients
   imgc_pkg::coef_type     coef_ff [W][W];
   imgc_pkg::coef_col_type coef_eff_ff [W];
   imgc_pkg::coef_col_type coef_eff_in [W];

   // pipeline
   imgc_pkg::ctrl_type c0, c1_ff, c2_ff, c3_ff, c4_ff;
   imgc_pkg::pix_type  pix_s1_ff;
   logic [imgc_pkg::ColBits-1:0]  col_s1_ff;
   logic [imgc_pkg::LineBits-1:0] line_rd;
   imgc_pkg::col_type  new_col;
   imgc_pkg::col_type  col_w [W];
   imgc_pkg::part_type part_w [W];
   logic signed [imgc_pkg::SumBits-1:0] sum_in, sum_ff;
   imgc_pkg::pix_type  clamp_pix;

   // output queue
   logic [imgc_pkg::PixBits:0]    fifo_ff [imgc_pkg::FifoDepth];
   logic [imgc_pkg::FifoBits-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [imgc_pkg::FifoBits:0]   count_ff;
   logic [imgc_pkg::FifoBits:0]   inflight;
   logic                          push, pop;

   logic accept, cfg_wr, emit, border, last_pos;
   logic [imgc_pkg::SizeBits:0] r_wide;

   assign csr_ready = 1'b1;
   assign cfg_wr    = csr_valid && csr_ready;
   assign accept    = req_valid && req_ready;

   // effective size and radius
   always_comb begin
      if (size_ff == '0) begin
         n_eff = imgc_pkg::SizeBits'(1);
      end else if (size_ff > imgc_pkg::SizeBits'(imgc_pkg::MaxSize)) begin
         n_eff = imgc_pkg::SizeBits'(imgc_pkg::MaxSize);
      end else begin
         n_eff = size_ff;
      end
      if (radius_ff > imgc_pkg::RadBits'(imgc_pkg::MaxRadius)) begin
         r_eff = imgc_pkg::RadBits'(imgc_pkg::MaxRadius);
      end else begin
         r_eff = radius_ff;
      end
      delay_in = imgc_pkg::PosBits'(r_eff);
      if (r_eff[1]) begin
         delay_in = delay_in + imgc_pkg::PosBits'({n_eff, 1'b0});
      end
      if (r_eff[0]) begin
         delay_in = delay_in + imgc_pkg::PosBits'(n_eff);
      end
   end

   assign r_wide = (imgc_pkg::SizeBits+1)'(r_eff);

   // coefficients placed at the bottom-right corner of the window
   always_comb begin
      for (int e = 0; e < W; e++) begin
         for (int k = 0; k < W; k++) begin
            coef_eff_in[k][e] = '0;
            for (int rr = 0; rr <= imgc_pkg::MaxRadius; rr++) begin
               if (r_eff == imgc_pkg::RadBits'(rr) && e >= W - 1 - 2 * rr
                   && k >= W - 1 - 2 * rr) begin
                  coef_eff_in[k][e] = coef_ff[e - (W - 1 - 2 * rr)][k - (W - 1 - 2 * rr)];
               end
            end
         end
      end
   end

   // border and end-of-image checks for the next result
   always_comb begin
      border = ({1'b0, out_row_ff} < r_wide)
            || ({1'b0, out_row_ff} + r_wide >= {1'b0, n_eff})
            || ({1'b0, out_col_ff} < r_wide)
            || ({1'b0, out_col_ff} + r_wide >= {1'b0, n_eff});
      last_pos = (out_pos_ff == nn_ff - imgc_pkg::PosBits'(1));
   end

   // command decode and counters
   always_comb begin
      in_row_in  = in_row_ff;
      in_col_in  = in_col_ff;
      q_in       = q_ff;
      out_pos_in = out_pos_ff;
      out_row_in = out_row_ff;
      out_col_in = out_col_ff;
      emit       = 1'b0;
      c0         = '0;
      if (accept) begin
         case (req_command)
            imgc_pkg::CmdPixel: begin
               if (in_row_ff < n_eff) begin
                  c0.shift = 1'b1;
                  q_in     = q_ff + imgc_pkg::PosBits'(1);
                  if (in_col_ff + imgc_pkg::SizeBits'(1) >= n_eff) begin
                     in_col_in = '0;
                     in_row_in = in_row_ff + imgc_pkg::SizeBits'(1);
                  end else begin
                     in_col_in = in_col_ff + imgc_pkg::SizeBits'(1);
                  end
                  emit = (q_ff == out_pos_ff + delay_ff);
               end
            end
            imgc_pkg::CmdDrain: begin
               emit = (in_row_ff >= n_eff) && (out_pos_ff < nn_ff);
            end
            default: begin
            end
         endcase
      end
      if (emit) begin
         c0.result = 1'b1;
         c0.border = border;
         c0.last   = last_pos;
         if (last_pos) begin
            in_row_in  = '0;
            in_col_in  = '0;
            q_in       = '0;
            out_pos_in = '0;
            out_row_in = '0;
            out_col_in = '0;
         end else begin
            out_pos_in = out_pos_ff + imgc_pkg::PosBits'(1);
            if (out_col_ff + imgc_pkg::SizeBits'(1) >= n_eff) begin
               out_col_in = '0;
               out_row_in = out_row_ff + imgc_pkg::SizeBits'(1);
            end else begin
               out_col_in = out_col_ff + imgc_pkg::SizeBits'(1);
            end
         end
      end
      if (cfg_wr) begin
         in_row_in  = '0;
         in_col_in  = '0;
         q_in       = '0;
         out_pos_in = '0;
         out_row_in = '0;
         out_col_in = '0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff    <= imgc_pkg::SizeBits'(8);
         radius_ff  <= imgc_pkg::RadBits'(1);
         settle_ff  <= 1'b1;
         in_row_ff  <= '0;
         in_col_ff  <= '0;
         q_ff       <= '0;
         out_pos_ff <= '0;
         out_row_ff <= '0;
         out_col_ff <= '0;
         c1_ff      <= '0;
         c2_ff      <= '0;
         c3_ff      <= '0;
         c4_ff      <= '0;
         for (int i = 0; i < W; i++) begin
            for (int j = 0; j < W; j++) begin
               coef_ff[i][j] <= '0;
            end
         end
      end else begin
         settle_ff  <= cfg_wr;
         if (cfg_wr) begin
            case (csr_index)
               imgc_pkg::RegSize:   size_ff   <= csr_data;
               imgc_pkg::RegRadius: radius_ff <= csr_data[imgc_pkg::RadBits-1:0];
               default: begin
               end
            endcase
         end
         in_row_ff  <= in_row_in;
         in_col_ff  <= in_col_in;
         q_ff       <= q_in;
         out_pos_ff <= out_pos_in;
         out_row_ff <= out_row_in;
         out_col_ff <= out_col_in;
         c1_ff      <= c0;
         c2_ff      <= c1_ff;
         c3_ff      <= c2_ff;
         c4_ff      <= c3_ff;
         // coefficient load, out-of-range indexes dropped
         if (accept && req_command == imgc_pkg::CmdLoad
             && req_coef_row < 3'(W) && req_coef_col < 3'(W)) begin
            coef_ff[req_coef_row][req_coef_col] <= req_coef_value;
         end
      end
   end

   // derived configuration and payload stages
   always_ff @(posedge clock) begin
      nn_ff       <= imgc_pkg::PosBits'(n_eff * n_eff);
      delay_ff    <= delay_in;
      coef_eff_ff <= coef_eff_in;
      pix_s1_ff   <= req_pixel;
      col_s1_ff   <= in_col_ff[imgc_pkg::ColBits-1:0];
      sum_ff      <= sum_in;
   end

   // line buffer holds the four rows above the current one
   imgc_line_buf u_line_buf (
      .clock   (clock),
      .rd_en   (c0.shift),
      .rd_addr (in_col_ff[imgc_pkg::ColBits-1:0]),
      .rd_data (line_rd),
      .wr_en   (c1_ff.shift),
      .wr_addr (col_s1_ff),
      .wr_data ({line_rd[imgc_pkg::LineBits-imgc_pkg::PixBits-1:0], pix_s1_ff})
   );

   // new window column, oldest row at element 0
   always_comb begin
      new_col[W-1] = pix_s1_ff;
      for (int e = 0; e < W - 1; e++) begin
         new_col[e] = line_rd[(W - 2 - e) * imgc_pkg::PixBits +: imgc_pkg::PixBits];
      end
   end

   // row of column cells, newest column enters at the right
   for (genvar k = 0; k < W; k++) begin : g_cell
      imgc_cell u_cell (
         .clock    (clock),
         .shift    (c1_ff.shift),
         .col_in   ((k == W - 1) ? new_col : col_w[(k == W - 1) ? k : k + 1]),
         .coef_col (coef_eff_ff[k]),
         .col_out  (col_w[k]),
         .part_out (part_w[k])
      );
   end

   // window sum and clamp
   always_comb begin
      sum_in = '0;
      for (int k = 0; k < W; k++) begin
         sum_in = sum_in + imgc_pkg::SumBits'(part_w[k]);
      end
      if (c4_ff.border || sum_ff < 0) begin
         clamp_pix = '0;
      end else if (sum_ff > imgc_pkg::SumBits'(imgc_pkg::PixMax)) begin
         clamp_pix = imgc_pkg::PixBits'(imgc_pkg::PixMax);
      end else begin
         clamp_pix = sum_ff[imgc_pkg::PixBits-1:0];
      end
   end

   // output queue
   assign push     = c4_ff.result;
   assign pop      = rsp_valid && rsp_ready;
   assign inflight = (imgc_pkg::FifoBits+1)'(c1_ff.result) + (imgc_pkg::FifoBits+1)'(c2_ff.result)
                   + (imgc_pkg::FifoBits+1)'(c3_ff.result) + (imgc_pkg::FifoBits+1)'(c4_ff.result);
   assign req_ready = !settle_ff
                   && (count_ff + inflight < (imgc_pkg::FifoBits+1)'(imgc_pkg::FifoDepth));

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            fifo_ff[wr_ptr_ff] <= {c4_ff.last, clamp_pix};
            wr_ptr_ff          <= wr_ptr_ff + imgc_pkg::FifoBits'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + imgc_pkg::FifoBits'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + (imgc_pkg::FifoBits+1)'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - (imgc_pkg::FifoBits+1)'(1);
         end
      end
   end

   assign rsp_valid     = (count_ff != '0);
   assign rsp_out_pixel = fifo_ff[rd_ptr_ff][imgc_pkg::PixBits-1:0];
   assign rsp_out_last  = fifo_ff[rd_ptr_ff][imgc_pkg::PixBits];

endmodule

[rtl/core/imgc_checker.sv]
module imgc_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [imgc_pkg::PixBits-1:0] rsp_out_pixel,
   input logic                         rsp_out_last,
   input logic                         csr_valid,
   input logic                         csr_ready
);

   // queue comes up empty
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown right after reset");

   // a register write holds off the next item for a cycle
   a_cfg_settle: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |=> !req_ready)
      else $error("item taken right after register write");

   // stalled result stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // stalled payload stays
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_out_pixel) && $stable(rsp_out_last))
      else $error("result changed while stalled");

endmodule

bind image_convolution_clamped imgc_checker u_imgc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_out_pixel (rsp_out_pixel),
   .rsp_out_last  (rsp_out_last),
   .csr_valid     (csr_valid),
   .csr_ready     (csr_ready)
);

[tb/image_convolution_clamped_tb.sv]
`timescale 1ns / 100ps

module image_convolution_clamped_tb;

   localparam logic [1:0] CmdUnused = 2'd3;
   localparam int CycleLimit = 400000;

   typedef struct {
      logic [imgc_pkg::PixBits-1:0] pix;
      logic                         last;
   } out_beat_type;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_ready;
   logic [1:0]                           req_command = imgc_pkg::CmdLoad;
   logic [2:0]                           req_coef_row = '0;
   logic [2:0]                           req_coef_col = '0;
   logic signed [imgc_pkg::CoefBits-1:0] req_coef_value = '0;
   logic [imgc_pkg::PixBits-1:0]         req_pixel = '0;
   logic                                 rsp_valid;
   logic                                 rsp_ready = 1'b0;
   logic [imgc_pkg::PixBits-1:0]         rsp_out_pixel;
   logic                                 rsp_out_last;
   logic                                 csr_valid = 1'b0;
   logic                                 csr_ready;
   logic [0:0]                           csr_index = imgc_pkg::RegSize;
   logic [imgc_pkg::SizeBits-1:0]        csr_data = '0;

   // filter state mirrored by the testbench
   logic signed [imgc_pkg::CoefBits-1:0] kernel [imgc_pkg::WinSide][imgc_pkg::WinSide];
   logic [imgc_pkg::PixBits-1:0]         rows_ring [imgc_pkg::WinSide][imgc_pkg::MaxSize];
   int                                   size_reg = 8;
   int                                   radius_reg = 1;
   int                                   at_row, at_col, next_out;

   out_beat_type filtered_q [$];
   int           errors = 0;
   int           beats_sent = 0;
   int           burst_left = 0;
   int           cycles = 0;
   int           stall_left = 0;
   int           stall_mode = 0;

   image_convolution_clamped dut (.*);

   always #5 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("image_convolution_clamped_tb NOT OK");
         $finish;
      end
   end

   // receiver stalls, one of four ready patterns, redrawn at random
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(10, 60);
      end
      stall_left = stall_left - 1;
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         2: rsp_ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ready <= cycles[2];
      endcase
   end

   // result checker
   always @(posedge clock) begin
      out_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (filtered_q.size() == 0) begin
            $display("%0t unexpected beat: actual pixel %0d last %0b", $time,
                     rsp_out_pixel, rsp_out_last);
            errors++;
         end else begin
            want = filtered_q.pop_front();
            if (rsp_out_pixel !== want.pix) begin
               $display("%0t out_pixel mismatch: expected %0d actual %0d", $time,
                        want.pix, rsp_out_pixel);
               errors++;
            end
            if (rsp_out_last !== want.last) begin
               $display("%0t out_last mismatch: expected %0b actual %0b", $time,
                        want.last, rsp_out_last);
               errors++;
            end
         end
      end
   end

   function automatic int eff_size();
      if (size_reg < 1) return 1;
      if (size_reg > imgc_pkg::MaxSize) return imgc_pkg::MaxSize;
      return size_reg;
   endfunction

   function automatic int eff_radius();
      return (radius_reg > imgc_pkg::MaxRadius) ? imgc_pkg::MaxRadius : radius_reg;
   endfunction

   // produce the result at next_out and advance
   function automatic void emit_filtered(int n, int r);
      out_beat_type res;
      longint       acc;
      int           oi, oj;
      oi = next_out / n;
      oj = next_out % n;
      res.pix = '0;
      if (!(oi < r || oi + r >= n || oj < r || oj + r >= n)) begin
         acc = 0;
         for (int i = 0; i <= 2 * r; i++)
            for (int j = 0; j <= 2 * r; j++)
               acc += longint'(rows_ring[(oi - r + i) % imgc_pkg::WinSide]
                                        [(oj - r + j) % imgc_pkg::MaxSize])
                      * longint'(kernel[i][j]);
         if (acc > imgc_pkg::PixMax) acc = imgc_pkg::PixMax;
         if (acc < 0) acc = 0;
         res.pix = acc[imgc_pkg::PixBits-1:0];
      end
      res.last = (next_out == n * n - 1);
      filtered_q.push_back(res);
      next_out++;
      if (next_out >= n * n) begin
         at_row = 0;
         at_col = 0;
         next_out = 0;
      end
   endfunction

   // apply one accepted request beat
   function automatic void filter_step(logic [1:0] cmd, logic [2:0] krow, logic [2:0] kcol,
                                       logic signed [imgc_pkg::CoefBits-1:0] coef,
                                       logic [imgc_pkg::PixBits-1:0] pix);
      int n, r, lag, q;
      n = eff_size();
      r = eff_radius();
      lag = r * n + r;
      case (cmd)
         imgc_pkg::CmdLoad:
            if (krow < imgc_pkg::WinSide && kcol < imgc_pkg::WinSide)
               kernel[krow][kcol] = coef;
         imgc_pkg::CmdPixel:
            if (at_row < n) begin
               q = at_row * n + at_col;
               rows_ring[at_row % imgc_pkg::WinSide][at_col % imgc_pkg::MaxSize] = pix;
               at_col++;
               if (at_col >= n) begin
                  at_col = 0;
                  at_row++;
               end
               if (q >= lag && q - lag == next_out) emit_filtered(n, r);
            end
         imgc_pkg::CmdDrain:
            if (at_row >= n && next_out < n * n) emit_filtered(n, r);
         default: ;
      endcase
   endfunction

   // send one request beat, bursts with random gaps
   task automatic send_beat(logic [1:0] cmd, logic [2:0] krow, logic [2:0] kcol,
                            logic signed [imgc_pkg::CoefBits-1:0] coef,
                            logic [imgc_pkg::PixBits-1:0] pix);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_command <= cmd;
      req_coef_row <= krow;
      req_coef_col <= kcol;
      req_coef_value <= coef;
      req_pixel <= pix;
      do @(posedge clock); while (!req_ready);
      filter_step(cmd, krow, kcol, coef, pix);
      beats_sent++;
   endtask

   task automatic send_pixel(logic [imgc_pkg::PixBits-1:0] pix);
      send_beat(imgc_pkg::CmdPixel, 3'($urandom), 3'($urandom),
                imgc_pkg::CoefBits'($urandom), pix);
   endtask

   task automatic send_drain();
      send_beat(imgc_pkg::CmdDrain, 3'($urandom), 3'($urandom),
                imgc_pkg::CoefBits'($urandom), imgc_pkg::PixBits'($urandom));
   endtask

   // hold off until every expected beat is out and the pipe is empty
   task automatic wait_drained();
      req_valid <= 1'b0;
      burst_left = 0;
      while (filtered_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(logic [0:0] idx, logic [imgc_pkg::SizeBits-1:0] data);
      wait_drained();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == imgc_pkg::RegSize) size_reg = data;
      else radius_reg = data[1:0];
      at_row = 0;
      at_col = 0;
      next_out = 0;
   endtask

   // stream one image, optionally cut short; a full image then flushes the trailing results
   task automatic stream_image(int n, int r, bit cut, bit pause);
      int total, stop;
      total = n * n;
      stop = cut ? $urandom_range(0, total) : total;
      for (int k = 0; k < stop; k++) begin
         if ($urandom_range(0, 19) == 0)
            send_beat(CmdUnused, 3'($urandom), 3'($urandom),
                      imgc_pkg::CoefBits'($urandom), imgc_pkg::PixBits'($urandom));
         if ($urandom_range(0, 24) == 0) send_drain();
         if ($urandom_range(0, 29) == 0)
            send_beat(imgc_pkg::CmdLoad, 3'($urandom_range(imgc_pkg::WinSide, 7)),
                      3'($urandom), imgc_pkg::CoefBits'($urandom),
                      imgc_pkg::PixBits'($urandom));
         if (pause && k == stop / 2) wait_drained();
         send_pixel(imgc_pkg::PixBits'($urandom));
      end
      if (!cut) begin
         if ($urandom_range(0, 2) == 0) send_pixel(imgc_pkg::PixBits'($urandom));
         repeat (r * n + r + $urandom_range(0, 2)) send_drain();
      end
   endtask

   task automatic load_kernel(bit wide);
      for (int i = 0; i < imgc_pkg::WinSide; i++)
         for (int j = 0; j < imgc_pkg::WinSide; j++)
            send_beat(imgc_pkg::CmdLoad, 3'(i), 3'(j),
                      wide ? imgc_pkg::CoefBits'($urandom)
                           : imgc_pkg::CoefBits'($urandom_range(0, 6) - 3), '0);
   endtask

   // coefficient extremes, ignored loads, early drain, unused command
   task automatic test_directed();
      send_beat(imgc_pkg::CmdLoad, 3'd0, 3'd0, 16'sh8000, '0);
      send_beat(imgc_pkg::CmdLoad, 3'd4, 3'd4, 16'sd32767, '0);
      send_beat(imgc_pkg::CmdLoad, 3'd7, 3'd7, 16'sd1, '0);
      send_beat(imgc_pkg::CmdLoad, 3'd1, 3'd1, 16'sd1, '0);
      send_beat(CmdUnused, 3'd7, 3'd7, -16'sd1, 8'hff);
      send_drain();
      write_reg(imgc_pkg::RegSize, 11'd3);
      for (int k = 0; k < 9; k++) send_pixel((k % 2) ? 8'hff : 8'h00);
      send_pixel(8'h5a);
      repeat (5) send_drain();
   endtask

   // size and radius out of range, large image abandoned part way
   task automatic test_size_extremes();
      write_reg(imgc_pkg::RegSize, 11'd0);
      write_reg(imgc_pkg::RegRadius, 11'h7fc);
      send_beat(imgc_pkg::CmdLoad, 3'd0, 3'd0, 16'sd1, '0);
      repeat (4) send_pixel(imgc_pkg::PixBits'($urandom));
      write_reg(imgc_pkg::RegRadius, 11'd3);
      send_pixel(8'hff);
      repeat (5) send_drain();
      write_reg(imgc_pkg::RegSize, 11'h7ff);
      write_reg(imgc_pkg::RegRadius, 11'd0);
      repeat (30) send_pixel(imgc_pkg::PixBits'($urandom));
      write_reg(imgc_pkg::RegRadius, 11'd2);
      repeat (20) send_pixel(imgc_pkg::PixBits'($urandom));
      write_reg(imgc_pkg::RegSize, 11'd1024);
      repeat (10) send_pixel(imgc_pkg::PixBits'($urandom));
   endtask

   // images over random settings, some cut short, mostly small sizes
   task automatic test_random_images();
      int n, r, count;
      count = 0;
      while (beats_sent < 340) begin
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 16) : $urandom_range(1, 8);
         r = $urandom_range(0, 3);
         write_reg(imgc_pkg::RegSize, imgc_pkg::SizeBits'(n));
         write_reg(imgc_pkg::RegRadius, {9'($urandom_range(0, 511)), r[1:0]});
         load_kernel($urandom_range(0, 3) == 0);
         stream_image(eff_size(), eff_radius(), $urandom_range(0, 7) == 0, count == 2);
         count++;
      end
   endtask

   initial begin
      for (int i = 0; i < imgc_pkg::WinSide; i++)
         for (int j = 0; j < imgc_pkg::WinSide; j++) kernel[i][j] = '0;
      at_row = 0;
      at_col = 0;
      next_out = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_size_extremes();
      test_random_images();
      wait_drained();
      repeat (20) @(posedge clock);
      if (errors == 0 && filtered_q.size() == 0) begin
         $display("image_convolution_clamped_tb OK");
      end else begin
         $display("image_convolution_clamped_tb NOT OK");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/core/imgc_pkg.sv
rtl/core/imgc_line_buf.sv
rtl/core/imgc_cell.sv
rtl/core/image_convolution_clamped.sv
rtl/core/imgc_checker.sv
tb/image_convolution_clamped_tb.sv
